@@ src/lpm_pkg.sv @@
package lpm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int IDX_W  = 6;
    localparam int CFG_W  = 7;
    localparam int IP_W   = 32;
    localparam int PORT_W = 8;
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] REG_ENTRIES_IN_USE = '0;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic [IP_W-1:0]   prefix;
        logic [IP_W-1:0]   mask;
        logic [IP_W-1:0]   hop;
        logic [PORT_W-1:0] port;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic              found;
        logic [IP_W-1:0]   hop;
        logic [IP_W-1:0]   mask;
        logic [PORT_W-1:0] port;
        logic [IDX_W-1:0]  slot;
    } t_result;

endpackage

@@ src/lpm_if.sv @@
interface lpm_req_if import lpm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [IDX_W-1:0]  entry_index;
    logic [IP_W-1:0]   entry_prefix;
    logic [IP_W-1:0]   entry_mask;
    logic [IP_W-1:0]   entry_next_hop;
    logic [PORT_W-1:0] entry_port;
    logic [IP_W-1:0]   dest_ip;

    modport source (
        output valid, cmd, entry_index, entry_prefix, entry_mask, entry_next_hop,
               entry_port, dest_ip,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, entry_prefix, entry_mask, entry_next_hop,
               entry_port, dest_ip,
        output ready
    );
endinterface

interface lpm_rsp_if import lpm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [IP_W-1:0]   hop_out;
    logic [IP_W-1:0]   mask_out;
    logic [PORT_W-1:0] port_out;
    logic [IDX_W-1:0]  slot_out;

    modport source (
        output valid, found, hop_out, mask_out, port_out, slot_out,
        input  ready
    );
    modport sink (
        input  valid, found, hop_out, mask_out, port_out, slot_out,
        output ready
    );
endinterface

@@ src/longest_prefix_match_lookup.sv @@
// lookup: scans min(entries_in_use, 64) entries; the next request waits until the result
// has moved into the output register
// write transaction: no result
// a single comparator reads one table entry per cycle from the route memory
// reset: synchronous active low, clears entries_in_use, sequencer and output valid;
// the route table is not cleared
module longest_prefix_match_lookup import lpm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lpm_req_if.sink           i_req,
    lpm_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [CFG_W-1:0] r_cfg;
    logic             r_out_valid;
    t_result          r_out;

    logic             w_busy;
    logic             w_accept;
    logic             w_we;
    logic             w_start;
    logic [CNT_W-1:0] w_limit;
    t_entry           w_wdata;
    t_entry           w_rdata;
    t_rd_req          w_rd;
    logic             w_res_valid;
    t_result          w_res;
    logic             w_take;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr == REG_ENTRIES_IN_USE) ? APB_DW'(r_cfg) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr == REG_ENTRIES_IN_USE)) begin
            r_cfg <= pwdata[CFG_W-1:0];
        end
    end

    assign w_limit = (32'(r_cfg) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(r_cfg);

    // input side
    assign i_req.ready = !w_busy;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_we        = w_accept && (i_req.cmd == CMD_WRITE)
                         && (32'(i_req.entry_index) < 32'(TABLE_DEPTH));
    assign w_start     = w_accept && (i_req.cmd == CMD_LOOKUP);

    always_comb begin
        w_wdata.prefix = i_req.entry_prefix;
        w_wdata.mask   = i_req.entry_mask;
        w_wdata.hop    = i_req.entry_next_hop;
        w_wdata.port   = i_req.entry_port;
    end

    lpm_table u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (ADDR_W'(i_req.entry_index)),
        .i_wdata (w_wdata),
        .i_rd    (w_rd),
        .o_rdata (w_rdata)
    );

    lpm_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_dest      (i_req.dest_ip),
        .i_limit     (w_limit),
        .o_busy      (w_busy),
        .o_rd        (w_rd),
        .i_rd_data   (w_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_take)
    );

    // output register
    assign w_take = w_res_valid && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
            r_out       <= w_res;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.found    = r_out.found;
    assign o_rsp.hop_out  = r_out.hop;
    assign o_rsp.mask_out = r_out.mask;
    assign o_rsp.port_out = r_out.port;
    assign o_rsp.slot_out = r_out.slot;

`ifndef ASSERT_OFF
    a_lookup_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.cmd == CMD_LOOKUP)) |=> !i_req.ready)
        else $error("lookup transaction did not start the scan");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.cmd == CMD_WRITE) && !o_rsp.valid) |=> !o_rsp.valid)
        else $error("write transaction produced a result");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.hop_out == '0) && (o_rsp.mask_out == '0)
            && (o_rsp.port_out == '0) && (o_rsp.slot_out == '0))
        else $error("miss result carries nonzero fields");

    a_take_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (!r_out_valid || o_rsp.ready))
        else $error("result overwrote a pending output");
`endif

endmodule

@@ src/lpm_table.sv @@
module lpm_table import lpm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  t_rd_req           i_rd,
    output t_entry            o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/lpm_scan.sv @@
module lpm_scan import lpm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IP_W-1:0]  i_dest,
    input  logic [CNT_W-1:0] i_limit,
    output logic             o_busy,
    output t_rd_req          o_rd,
    input  t_entry           i_rd_data,
    output logic             o_res_valid,
    output t_result          o_res,
    input  logic             i_res_take
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [IP_W-1:0]    r_dest;
    logic [CNT_W-1:0]   r_limit;
    logic [CNT_W-1:0]   r_idx;
    logic               r_cmp_valid;
    logic [ADDR_W-1:0]  r_cmp_slot;
    logic               r_hit;
    logic [IP_W-1:0]    r_mask;
    logic [IP_W-1:0]    r_hop;
    logic [PORT_W-1:0]  r_port;
    logic [ADDR_W-1:0]  r_slot;

    logic w_match;
    logic w_better;

    always_comb begin
        o_rd.en   = (r_state == S_SCAN) && (r_idx < r_limit);
        o_rd.addr = r_idx[ADDR_W-1:0];
    end

    assign w_match  = ((i_rd_data.mask & r_dest) == i_rd_data.prefix);
    assign w_better = !r_hit || (i_rd_data.mask > r_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cmp_valid <= 1'b0;
                    if (i_start) begin
                        r_dest  <= i_dest;
                        r_limit <= i_limit;
                        r_idx   <= '0;
                        r_hit   <= 1'b0;
                        r_mask  <= '0;
                        r_hop   <= '0;
                        r_port  <= '0;
                        r_slot  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_idx       <= r_idx + CNT_W'(o_rd.en);
                    r_cmp_valid <= o_rd.en;
                    r_cmp_slot  <= o_rd.addr;
                    if (r_cmp_valid && w_match && w_better) begin
                        r_hit  <= 1'b1;
                        r_mask <= i_rd_data.mask;
                        r_hop  <= i_rd_data.hop;
                        r_port <= i_rd_data.port;
                        r_slot <= r_cmp_slot;
                    end
                    if (!o_rd.en && !r_cmp_valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.found = r_hit;
        o_res.hop   = r_hop;
        o_res.mask  = r_mask;
        o_res.port  = r_port;
        o_res.slot  = IDX_W'(r_slot);
    end

endmodule

@@ sim/tb_longest_prefix_match_lookup.sv @@
`timescale 1ns / 100ps

module tb_longest_prefix_match_lookup;
    import lpm_pkg::*;

    localparam int IDLE_WAIT   = TABLE_DEPTH + 16;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 145;

    typedef struct {
        logic             cmd;
        logic [IDX_W-1:0] index;
        t_entry           entry;
        logic [IP_W-1:0]  dest;
    } t_request;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    lpm_req_if req_if ();
    lpm_rsp_if rsp_if ();

    longest_prefix_match_lookup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_entry          route_table [TABLE_DEPTH];
    int unsigned     active_entries;
    t_result         pending_routes [$];
    int              error_count;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              hold_request;
    int              quiet_cycles;
    logic [IP_W-1:0] net_pool [4];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result best_route(logic [IP_W-1:0] dest);
        t_result     res;
        int unsigned limit;
        res   = '0;
        limit = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : active_entries;
        for (int i = 0; i < limit; i++) begin
            if ((route_table[i].mask & dest) == route_table[i].prefix &&
                (!res.found || route_table[i].mask > res.mask)) begin
                res.found = 1'b1;
                res.hop   = route_table[i].hop;
                res.mask  = route_table[i].mask;
                res.port  = route_table[i].port;
                res.slot  = IDX_W'(i);
            end
        end
        return res;
    endfunction

    function automatic t_entry random_route();
        t_entry          e;
        int              kind;
        int              len;
        logic [IP_W-1:0] base;
        kind   = $urandom_range(9);
        len    = $urandom_range(32);
        base   = (net_pool[$urandom_range(3)] & 32'hFFFF_0000) | ($urandom() & 32'h0000_FFFF);
        e.hop  = $urandom();
        e.port = PORT_W'($urandom_range(255));
        if (kind < 8) begin
            e.mask   = 32'hFFFF_FFFF << (32 - len);
            e.prefix = base & e.mask;
        end else if (kind == 8) begin
            // non-contiguous mask
            e.mask   = $urandom();
            e.prefix = base & e.mask;
        end else begin
            e.mask   = $urandom();
            e.prefix = $urandom();
        end
        return e;
    endfunction

    function automatic logic [IP_W-1:0] random_dest();
        int          kind;
        int unsigned limit;
        int          slot;
        kind  = $urandom_range(9);
        limit = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : active_entries;
        if (kind < 7 && limit > 0) begin
            slot = $urandom_range(limit - 1);
            return route_table[slot].prefix | ($urandom() & ~route_table[slot].mask);
        end
        if (kind < 9)
            return (net_pool[$urandom_range(3)] & 32'hFFFF_0000) | ($urandom() & 32'h0000_FFFF);
        return $urandom();
    endfunction

    function automatic t_request random_request();
        t_request r;
        r.cmd   = ($urandom_range(9) < 7) ? CMD_LOOKUP : CMD_WRITE;
        r.index = IDX_W'($urandom_range(TABLE_DEPTH - 1));
        r.entry = random_route();
        r.dest  = (r.cmd == CMD_LOOKUP) ? random_dest() : IP_W'($urandom());
        return r;
    endfunction

    task automatic send_item(t_request item);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.cmd            <= item.cmd;
        req_if.entry_index    <= item.index;
        req_if.entry_prefix   <= item.entry.prefix;
        req_if.entry_mask     <= item.entry.mask;
        req_if.entry_next_hop <= item.entry.hop;
        req_if.entry_port     <= item.entry.port;
        req_if.dest_ip        <= item.dest;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        if (item.cmd == CMD_WRITE)
            route_table[item.index] = item.entry;
        else
            pending_routes.push_back(best_route(item.dest));
    endtask

    task automatic write_route(int idx, logic [IP_W-1:0] prefix, logic [IP_W-1:0] mask,
                               logic [IP_W-1:0] hop, logic [PORT_W-1:0] port);
        t_request r;
        r.cmd          = CMD_WRITE;
        r.index        = IDX_W'(idx);
        r.entry.prefix = prefix;
        r.entry.mask   = mask;
        r.entry.hop    = hop;
        r.entry.port   = port;
        r.dest         = $urandom();
        send_item(r);
    endtask

    task automatic look_up(logic [IP_W-1:0] dest);
        t_request r;
        r       = random_request();
        r.cmd   = CMD_LOOKUP;
        r.dest  = dest;
        send_item(r);
    endtask

    task automatic finish_burst();
        req_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_routes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic settle();
        @(posedge i_clk);
        wait_drained();
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_entries_in_use(logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ENTRIES_IN_USE;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        active_entries = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[CFG_W-1:0] !== value) begin
            $error("entries_in_use: expected %0d, got %0d", value, prdata[CFG_W-1:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_empty_table();
        set_entries_in_use(CFG_W'(0));
        look_up(32'h0000_0000);
        look_up(32'hFFFF_FFFF);
        finish_burst();
    endtask

    task automatic test_directed_routes();
        settle();
        set_entries_in_use(CFG_W'(8));
        write_route(0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'd0);
        write_route(1, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 8'd1);
        write_route(2, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 8'd2);
        write_route(3, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FD, 8'd3);
        write_route(4, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0A01_02FE, 8'd4);
        write_route(5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
        write_route(6, 32'h0A00_0003, 32'hFF00_00FF, 32'h0A00_0301, 8'd6);
        write_route(7, 32'h0000_0001, 32'h0000_0000, $urandom(), 8'd7);
        look_up(32'h0A01_0203);
        look_up(32'h0A01_FFFF);
        look_up(32'h0A02_0304);
        look_up(32'h0B00_0000);
        look_up(32'hFFFF_FFFF);
        look_up(32'h0A7F_0003);
        look_up(32'h0000_0000);
        finish_burst();
        settle();
        set_entries_in_use(CFG_W'(1));
        look_up(32'h0A01_0203);
        finish_burst();
        settle();
        set_entries_in_use(CFG_W'(0));
        look_up(32'h0A01_0203);
        finish_burst();
    endtask

    task automatic test_table_fill();
        settle();
        send_idle_pct = 7;
        recv_idle_pct = 81;
        for (int i = 0; i < TABLE_DEPTH; i++)
            write_route(i, 32'h0, 32'h0, 32'h0, 8'd0);
        finish_burst();
        settle();
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            t_entry e;
            e = random_route();
            write_route(i, e.prefix, e.mask, e.hop, e.port);
        end
        finish_burst();
    endtask

    task automatic test_random_traffic();
        int unsigned counts [9];
        counts    = '{64, 127, 3, 1, 100, 0, 16, 65, 0};
        counts[5] = $urandom_range(1, 127);
        counts[8] = $urandom_range(1, 64);
        for (int p = 0; p < 9; p++) begin
            send_idle_pct = (p < 3) ? 7 : (p < 6) ? 81 : 0;
            recv_idle_pct = (p < 3) ? 81 : (p < 6) ? 7 : 0;
            settle();
            set_entries_in_use(CFG_W'(counts[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(199) == 0) begin
                    req_if.valid <= 1'b0;
                    @(posedge i_clk);
                    wait_drained();
                end
                send_item(random_request());
            end
            finish_burst();
        end
    endtask

    task automatic test_backpressure();
        t_request r;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle();
        set_entries_in_use(CFG_W'(4));
        hold_request = HOLD_CYCLES;
        for (int n = 0; n < 40; n++) begin
            r     = random_request();
            r.cmd = CMD_LOOKUP;
            r.dest = random_dest();
            send_item(r);
        end
        // sender stops until every lookup has answered
        finish_burst();
        @(posedge i_clk);
        wait_drained();
        for (int n = 0; n < 10; n++)
            send_item(random_request());
        finish_burst();
    endtask

    // response side: random stalls, long hold-off on request, result check
    initial begin
        int      hold;
        t_result want;
        hold         = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                if (pending_routes.size() == 0) begin
                    $error("result transaction with no lookup outstanding");
                    error_count++;
                end else begin
                    want = pending_routes.pop_front();
                    if (rsp_if.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, rsp_if.found);
                        error_count++;
                    end
                    if (rsp_if.hop_out !== want.hop) begin
                        $error("hop_out: expected %h, got %h", want.hop, rsp_if.hop_out);
                        error_count++;
                    end
                    if (rsp_if.mask_out !== want.mask) begin
                        $error("mask_out: expected %h, got %h", want.mask, rsp_if.mask_out);
                        error_count++;
                    end
                    if (rsp_if.port_out !== want.port) begin
                        $error("port_out: expected %0d, got %0d", want.port, rsp_if.port_out);
                        error_count++;
                    end
                    if (rsp_if.slot_out !== want.slot) begin
                        $error("slot_out: expected %0d, got %0d", want.slot, rsp_if.slot_out);
                        error_count++;
                    end
                end
            end
            if (hold_request > 0) begin
                hold         = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                hold--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || psel || (req_if.valid && req_if.ready) ||
                (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_if.valid          = 1'b0;
        req_if.cmd            = CMD_WRITE;
        req_if.entry_index    = '0;
        req_if.entry_prefix   = '0;
        req_if.entry_mask     = '0;
        req_if.entry_next_hop = '0;
        req_if.entry_port     = '0;
        req_if.dest_ip        = '0;
        error_count           = 0;
        active_entries        = 0;
        hold_request          = 0;
        send_idle_pct         = 0;
        recv_idle_pct         = 0;
        foreach (route_table[k])
            route_table[k] = '0;
        foreach (net_pool[k])
            net_pool[k] = $urandom();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_directed_routes();
        test_table_fill();
        test_random_traffic();
        test_backpressure();

        @(posedge i_clk);
        wait_drained();
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
